// ===== rtl/core/ntv_pkg.sv =====
package ntv_pkg;

	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned LIMIT_W         = 12;
	localparam int unsigned LEN_W           = LIMIT_W + 1;
	localparam int unsigned LIMIT_FIELD_MAX = (1 << LIMIT_W) - 1;
	localparam int unsigned LENGTH_LIMIT_MAX_DEF = 4095;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(255);

	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_EXP_L = 8'h65;
	localparam logic [BYTE_W-1:0] CH_EXP_U = 8'h45;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	// bytes below this value are control characters and split tokens
	localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd20;

	typedef enum logic [2:0] {
		INT_REJECT = 3'd0,
		INT_START  = 3'd1,
		INT_SIGNED = 3'd3,
		INT_DIGITS = 3'd4
	} int_state_t;

	typedef enum logic [3:0] {
		REAL_REJECT     = 4'd0,
		REAL_START      = 4'd1,
		REAL_SIGNED     = 4'd3,
		REAL_INT_DIGITS = 4'd4,
		REAL_AFTER_DOT  = 4'd5,
		REAL_FRAC       = 4'd6,
		REAL_AFTER_EXP  = 4'd7,
		REAL_EXP_SIGNED = 4'd8,
		REAL_EXP_DIGITS = 4'd9
	} real_state_t;

	typedef enum logic [1:0] {
		ST_TOKEN_END    = 2'd0,
		ST_TOO_LONG     = 2'd1,
		ST_END_NO_TOKEN = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              stream_end;
	} beat_t;

	typedef struct packed {
		logic             integer_ok;
		logic             real_ok;
		logic [LEN_W-1:0] token_length;
		status_t          status;
	} result_t;

endpackage

// ===== rtl/core/ntv_ifs.sv =====
interface ntv_byte_if;
	import ntv_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_value;
	logic              stream_end;

	modport source(output valid, byte_value, stream_end, input ready);
	modport sink(input valid, byte_value, stream_end, output ready);
endinterface

interface ntv_result_if;
	import ntv_pkg::*;
	logic             valid;
	logic             ready;
	logic             integer_ok;
	logic             real_ok;
	logic [LEN_W-1:0] token_length;
	status_t          status;

	modport source(output valid, integer_ok, real_ok, token_length, status, input ready);
	modport sink(input valid, integer_ok, real_ok, token_length, status, output ready);
endinterface

// ===== rtl/core/ntv_in_stage.sv =====
module ntv_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	ntv_byte_if.sink       in_ch,
	input  logic           advance,
	output logic           valid_s1,
	output ntv_pkg::beat_t beat_s1
);
	import ntv_pkg::*;

	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			beat_s1.byte_value <= in_ch.byte_value;
			beat_s1.stream_end <= in_ch.stream_end;
		end
	end

endmodule

// ===== rtl/core/ntv_tracker.sv =====
module ntv_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  ntv_pkg::beat_t                beat,
	input  logic [ntv_pkg::LIMIT_W-1:0]   limit,
	output logic                          has_result,
	output ntv_pkg::result_t              result
);
	import ntv_pkg::*;

	int_state_t       int_q, int_n;
	real_state_t      real_q, real_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             inside_q;

	logic is_digit, is_sign, is_exp, delim, too_long;
	logic [BYTE_W-1:0] b;

	assign b        = beat.byte_value;
	assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
	assign is_exp   = (b == CH_EXP_L) || (b == CH_EXP_U);
	assign delim    = (b == CH_SPACE) || (b < CTRL_LIMIT) || b[BYTE_W-1];

	// integer grammar next state
	always_comb begin
		int_n = INT_REJECT;
		if (delim) begin
			int_n = int_q;
		end else begin
			case (int_q)
				INT_START: begin
					if (is_sign)       int_n = INT_SIGNED;
					else if (is_digit) int_n = INT_DIGITS;
				end
				INT_SIGNED, INT_DIGITS: begin
					if (is_digit) int_n = INT_DIGITS;
				end
				default: int_n = INT_REJECT;
			endcase
		end
	end

	// real grammar next state
	always_comb begin
		real_n = REAL_REJECT;
		if (delim) begin
			real_n = real_q;
		end else begin
			case (real_q)
				REAL_START: begin
					if (is_sign)       real_n = REAL_SIGNED;
					else if (is_digit) real_n = REAL_INT_DIGITS;
				end
				REAL_SIGNED: begin
					if (is_digit) real_n = REAL_INT_DIGITS;
				end
				REAL_INT_DIGITS: begin
					if (is_digit)          real_n = REAL_INT_DIGITS;
					else if (b == CH_DOT)  real_n = REAL_AFTER_DOT;
					else if (is_exp)       real_n = REAL_AFTER_EXP;
				end
				REAL_AFTER_DOT: begin
					if (is_digit) real_n = REAL_FRAC;
				end
				REAL_FRAC: begin
					if (is_digit)    real_n = REAL_FRAC;
					else if (is_exp) real_n = REAL_AFTER_EXP;
				end
				REAL_AFTER_EXP: begin
					if (is_sign)       real_n = REAL_EXP_SIGNED;
					else if (is_digit) real_n = REAL_EXP_DIGITS;
				end
				REAL_EXP_SIGNED, REAL_EXP_DIGITS: begin
					if (is_digit) real_n = REAL_EXP_DIGITS;
				end
				default: real_n = REAL_REJECT;
			endcase
		end
	end

	// saturate one past the limit
	always_comb begin
		len_n = len_q;
		if (!delim && (len_q <= {1'b0, limit})) begin
			len_n = len_q + LEN_W'(1);
		end
	end

	assign too_long = len_n > {1'b0, limit};

	// result outputs
	always_comb begin
		has_result          = 1'b0;
		result.integer_ok   = 1'b0;
		result.real_ok      = 1'b0;
		result.token_length = len_n;
		result.status       = ST_TOKEN_END;
		if (!delim) begin
			has_result = beat.stream_end;
		end else if (!inside_q) begin
			has_result = beat.stream_end;
		end else begin
			has_result = 1'b1;
		end
		if (delim && !inside_q) begin
			result.token_length = '0;
			result.status       = ST_END_NO_TOKEN;
		end else if (too_long) begin
			result.status = ST_TOO_LONG;
		end else begin
			result.integer_ok = (int_n == INT_DIGITS);
			result.real_ok    = (real_n == REAL_INT_DIGITS) || (real_n == REAL_FRAC) ||
			                    (real_n == REAL_EXP_DIGITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q    <= INT_START;
			real_q   <= REAL_START;
			len_q    <= '0;
			inside_q <= 1'b0;
		end else if (advance) begin
			if (has_result) begin
				int_q    <= INT_START;
				real_q   <= REAL_START;
				len_q    <= '0;
				inside_q <= 1'b0;
			end else if (!delim) begin
				int_q    <= int_n;
				real_q   <= real_n;
				len_q    <= len_n;
				inside_q <= 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/numeric_token_validator.sv =====
// Numeric token validator.
// in_ch carries one text byte per beat (byte_value, stream_end); whitespace,
// control bytes below decimal 20 and bytes with the top bit set split the stream into tokens.
// out_ch carries one beat per finished token: integer_ok, real_ok,
// token_length and status (token end, too long, or end of stream with no
// open token). The user must write max_token_length through max_token_length_we
// and max_token_length only while the block is idle; the block does not enforce
// it. The limit in force is that value capped at LENGTH_LIMIT_MAX.
// Throughput: one byte per cycle while out_ch does not stall. A byte is held in
// the input register while the grammar step works on it, then the result lands
// in the output register, so the byte that ends a token passes through the input
// register and its result through the output register before it is valid.
// Reset clears the grammar states, the length count and both valid flags and
// loads a limit of 255. When out_ch stalls, the result register holds; the
// input register keeps taking bytes that end no token, and a byte that ends a
// token waits in it, which drops in_ch.ready until the result is taken.
module numeric_token_validator #(
	parameter int unsigned LENGTH_LIMIT_MAX = ntv_pkg::LENGTH_LIMIT_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ntv_byte_if.sink                    in_ch,
	ntv_result_if.source                out_ch,
	input  logic                        max_token_length_we,
	input  logic [ntv_pkg::LIMIT_W-1:0] max_token_length
);
	import ntv_pkg::*;

	localparam int unsigned LimCap =
		(LENGTH_LIMIT_MAX > LIMIT_FIELD_MAX) ? LIMIT_FIELD_MAX : LENGTH_LIMIT_MAX;
	localparam logic [LIMIT_W-1:0] LIM_CAP = LIMIT_W'(LimCap);

	logic [LIMIT_W-1:0] limit_cfg_q, limit;
	logic               valid_s1, advance, has_result, out_valid_q;
	beat_t              beat_s1;
	result_t            result, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_cfg_q <= LIMIT_RESET;
		end else if (max_token_length_we) begin
			limit_cfg_q <= max_token_length;
		end
	end

	assign limit = (limit_cfg_q > LIM_CAP) ? LIM_CAP : limit_cfg_q;

	// hold the byte only when it has a result and the output slot is full and not being taken
	assign advance = valid_s1 && (!has_result || !out_valid_q || out_ch.ready);

	ntv_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	ntv_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.beat       (beat_s1),
		.limit      (limit),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_q <= result;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.integer_ok   = out_q.integer_ok;
	assign out_ch.real_ok      = out_q.real_ok;
	assign out_ch.token_length = out_q.token_length;
	assign out_ch.status       = out_q.status;

endmodule

// ===== rtl/core/ntv_checker.sv =====
module ntv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      integer_ok,
	input logic                      real_ok,
	input logic [ntv_pkg::LEN_W-1:0] token_length,
	input ntv_pkg::status_t          status
);
	import ntv_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_length) && $stable(status)
		&& $stable(integer_ok) && $stable(real_ok))
		else $error("result beat changed while stalled");

	a_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_END_NO_TOKEN) |->
		!integer_ok && !real_ok && (token_length == '0))
		else $error("end without token carries token data");

	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TOO_LONG) |->
		!integer_ok && !real_ok && (token_length != '0))
		else $error("too long token has flags set or zero length");

	a_int_real: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && integer_ok |-> real_ok && (status == ST_TOKEN_END)
		&& (token_length != '0))
		else $error("integer token not accepted as real");

endmodule

bind numeric_token_validator ntv_checker u_ntv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.integer_ok   (out_ch.integer_ok),
	.real_ok      (out_ch.real_ok),
	.token_length (out_ch.token_length),
	.status       (out_ch.status)
);
